// ===== rtl/dtsl_pkg.sv =====
// Shared types, constants and the speed reciprocal table of the display slew limiter.
package dtsl_pkg;

	localparam int TEMP_W     = 15;
	localparam int DIFF_W     = TEMP_W + 1;
	localparam int NEXT_W     = TEMP_W + 2;
	localparam int MS_W       = 10;
	localparam int LIMIT_W    = 10;
	localparam int MIN_STEP_W = 8;
	localparam int MOVE_W     = LIMIT_W + 1;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 1;

	// step = floor(speed10 * scale10 * ms * 16 / 100000) = floor(ms * K / 6250).
	// Each entry holds ceil(K * 2^RECIP_SHIFT / 6250); 2^23 > 1023 * 6250 keeps it exact.
	localparam int RECIP_SHIFT = 23;
	localparam int RECIP_W     = 25;
	localparam int PROD_W      = RECIP_W + MS_W;
	localparam int RAW_STEP_W  = PROD_W - RECIP_SHIFT;

	localparam int SPEED_N = 9;
	localparam int SCALE_N = 3;
	localparam longint unsigned RECIP_DEN = 64'd6250;

	localparam logic signed [TEMP_W-1:0] TEMP_MIN   = 15'sh4000;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX   = 15'sh3fff;
	localparam logic signed [TEMP_W-1:0] STAGE_LOW  = 15'sd2400;
	localparam logic signed [TEMP_W-1:0] STAGE_HIGH = 15'sd4800;

	localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 10'd240;
	localparam logic [MIN_STEP_W-1:0] MIN_STEP_RESET = 8'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_LIMIT = 1'b0,
		REG_MIN_STEP   = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SCALE_SLOW  = 2'd0,
		SCALE_MID   = 2'd1,
		SCALE_HOT   = 2'd2
	} scale_sel_t;

	typedef struct packed {
		logic [LIMIT_W-1:0]    step;
		logic [TEMP_W-1:0]     mag;
		logic                  neg;
	} step_info_t;

	localparam logic [RECIP_W-1:0] RECIP_TBL [SPEED_N][SCALE_N] = '{
		'{RECIP_W'(((64'd1200 * 64'd18) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd1200 * 64'd10) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd1200 * 64'd9)  << RECIP_SHIFT) / RECIP_DEN + 64'd1)},
		'{RECIP_W'(((64'd800 * 64'd18) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd800 * 64'd10) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd800 * 64'd9)  << RECIP_SHIFT) / RECIP_DEN + 64'd1)},
		'{RECIP_W'(((64'd600 * 64'd18) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd600 * 64'd10) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd600 * 64'd9)  << RECIP_SHIFT) / RECIP_DEN + 64'd1)},
		'{RECIP_W'(((64'd400 * 64'd18) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd400 * 64'd10) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd400 * 64'd9)  << RECIP_SHIFT) / RECIP_DEN + 64'd1)},
		'{RECIP_W'(((64'd250 * 64'd18) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd250 * 64'd10) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd250 * 64'd9)  << RECIP_SHIFT) / RECIP_DEN + 64'd1)},
		'{RECIP_W'(((64'd150 * 64'd18) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd150 * 64'd10) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd150 * 64'd9)  << RECIP_SHIFT) / RECIP_DEN + 64'd1)},
		'{RECIP_W'(((64'd60 * 64'd18) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd60 * 64'd10) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd60 * 64'd9)  << RECIP_SHIFT) / RECIP_DEN + 64'd1)},
		'{RECIP_W'(((64'd30 * 64'd18) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd30 * 64'd10) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd30 * 64'd9)  << RECIP_SHIFT) / RECIP_DEN + 64'd1)},
		'{RECIP_W'(((64'd15 * 64'd18) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd15 * 64'd10) << RECIP_SHIFT) / RECIP_DEN + 64'd1),
		  RECIP_W'(((64'd15 * 64'd9)  << RECIP_SHIFT) / RECIP_DEN + 64'd1)}
	};

endpackage

// ===== rtl/dtsl_in_if.sv =====
// Input channel: measured temperature, elapsed time and heater flags.
interface dtsl_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [dtsl_pkg::TEMP_W-1:0]    measured_temp;
	logic [dtsl_pkg::MS_W-1:0]             elapsed_ms;
	logic                                  control_enabled;
	logic                                  heating_on;

	modport source(output valid, measured_temp, elapsed_ms, control_enabled, heating_on,
		input ready);
	modport sink(input valid, measured_temp, elapsed_ms, control_enabled, heating_on,
		output ready);
endinterface

// ===== rtl/dtsl_out_if.sv =====
// Result channel: new displayed temperature and landing flag.
interface dtsl_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [dtsl_pkg::TEMP_W-1:0]    display_temp;
	logic                                  reached_target;

	modport source(output valid, display_temp, reached_target, input ready);
	modport sink(input valid, display_temp, reached_target, output ready);
endinterface

// ===== rtl/display_temperature_slew_limiter.sv =====
// Display temperature slew limiter: moves the shown temperature toward each measurement.
//
// item_in carries measured_temp (1/16 C), elapsed_ms and the two heater flags;
// result_out returns display_temp and reached_target, one result per item.
// Both channels transfer when valid and ready are high at a rising clk edge.
// cfg_we writes cfg_data into the step limit (index 0) or min_step (index 1);
// write only while no item is in flight.
// Throughput: one item per cycle while results are taken; the shown-temperature loop closes
// through the shown_q register and one rate multiply (10 x 25 bits).
// A stalled receiver holds the result register; one more item waits in the
// input register and item_in.ready drops until the result is taken.
// arst_n clears the shown temperature to 0, empties both registers and loads
// a step limit of 240 and min_step = 8.
module display_temperature_slew_limiter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [dtsl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dtsl_pkg::CFG_DATA_W-1:0]       cfg_data,
	dtsl_in_if.sink                               item_in,
	dtsl_out_if.source                            result_out
);
	logic [dtsl_pkg::LIMIT_W-1:0]          step_limit_q;
	logic [dtsl_pkg::MIN_STEP_W-1:0]       min_step_q;
	logic signed [dtsl_pkg::TEMP_W-1:0]    shown_q;

	logic                                  valid_s1;
	logic signed [dtsl_pkg::TEMP_W-1:0]    meas_s1;
	logic [dtsl_pkg::MS_W-1:0]             ms_s1;
	logic                                  slew_en_s1;

	logic                                  valid_s2;
	logic signed [dtsl_pkg::TEMP_W-1:0]    display_s2;
	logic                                  reached_s2;

	logic                                  advance;
	dtsl_pkg::step_info_t                  info;
	logic signed [dtsl_pkg::TEMP_W-1:0]    next_temp;
	logic                                  reached;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_limit_q <= dtsl_pkg::LIMIT_RESET;
			min_step_q   <= dtsl_pkg::MIN_STEP_RESET;
		end else if (cfg_we) begin
			unique case (dtsl_pkg::cfg_reg_t'(cfg_index))
				dtsl_pkg::REG_STEP_LIMIT: step_limit_q <= cfg_data[dtsl_pkg::LIMIT_W-1:0];
				dtsl_pkg::REG_MIN_STEP:   min_step_q <= cfg_data[dtsl_pkg::MIN_STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance       = valid_s1 && (!valid_s2 || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			meas_s1    <= item_in.measured_temp;
			ms_s1      <= item_in.elapsed_ms;
			slew_en_s1 <= item_in.control_enabled && item_in.heating_on;
		end
	end

	dtsl_step u_step (
		.measured_temp (meas_s1),
		.shown_temp    (shown_q),
		.elapsed_ms    (ms_s1),
		.step_limit    (step_limit_q),
		.info          (info)
	);

	dtsl_next u_next (
		.measured_temp (meas_s1),
		.shown_temp    (shown_q),
		.slew_en       (slew_en_s1),
		.info          (info),
		.min_step      (min_step_q),
		.next_temp     (next_temp),
		.reached       (reached)
	);

	// commit the new shown temperature together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			shown_q  <= next_temp;
			valid_s2 <= 1'b1;
		end else if (result_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			display_s2 <= next_temp;
			reached_s2 <= reached;
		end
	end

	assign result_out.valid          = valid_s2;
	assign result_out.display_temp   = display_s2;
	assign result_out.reached_target = reached_s2;
endmodule

// ===== rtl/dtsl_step.sv =====
// Step size: difference, speed ladder, stage scale, rate multiply and clamp.
module dtsl_step (
	input  logic signed [dtsl_pkg::TEMP_W-1:0]     measured_temp,
	input  logic signed [dtsl_pkg::TEMP_W-1:0]     shown_temp,
	input  logic [dtsl_pkg::MS_W-1:0]              elapsed_ms,
	input  logic [dtsl_pkg::LIMIT_W-1:0]           step_limit,
	output dtsl_pkg::step_info_t                   info
);
	logic signed [dtsl_pkg::DIFF_W-1:0]   diff;
	logic [dtsl_pkg::DIFF_W-1:0]          mag_full;
	logic [dtsl_pkg::TEMP_W-1:0]          mag;
	logic [3:0]                           speed_idx;
	dtsl_pkg::scale_sel_t                 scale_sel;
	logic [dtsl_pkg::RECIP_W-1:0]         recip;
	logic [dtsl_pkg::PROD_W-1:0]          prod;
	logic [dtsl_pkg::RAW_STEP_W-1:0]      raw_step;

	assign diff     = dtsl_pkg::DIFF_W'(measured_temp) - dtsl_pkg::DIFF_W'(shown_temp);
	assign mag_full = diff[dtsl_pkg::DIFF_W-1] ? dtsl_pkg::DIFF_W'(-diff)
		: dtsl_pkg::DIFF_W'(diff);
	// |diff| never exceeds 32767, so the top bit is always clear
	assign mag = mag_full[dtsl_pkg::TEMP_W-1:0];

	always_comb begin
		priority if (mag > 15'd1600) speed_idx = 4'd0;
		else if (mag > 15'd800)      speed_idx = 4'd1;
		else if (mag > 15'd480)      speed_idx = 4'd2;
		else if (mag > 15'd240)      speed_idx = 4'd3;
		else if (mag > 15'd128)      speed_idx = 4'd4;
		else if (mag > 15'd48)       speed_idx = 4'd5;
		else if (mag > 15'd32)       speed_idx = 4'd6;
		else if (mag > 15'd16)       speed_idx = 4'd7;
		else                         speed_idx = 4'd8;
	end

	always_comb begin
		priority if (shown_temp < dtsl_pkg::STAGE_LOW)  scale_sel = dtsl_pkg::SCALE_SLOW;
		else if (shown_temp > dtsl_pkg::STAGE_HIGH)     scale_sel = dtsl_pkg::SCALE_HOT;
		else                                            scale_sel = dtsl_pkg::SCALE_MID;
	end

	assign recip = dtsl_pkg::RECIP_TBL[speed_idx][scale_sel];

	assign prod     = dtsl_pkg::PROD_W'(elapsed_ms) * dtsl_pkg::PROD_W'(recip);
	assign raw_step = prod[dtsl_pkg::PROD_W-1:dtsl_pkg::RECIP_SHIFT];

	always_comb begin
		info.mag = mag;
		info.neg = diff[dtsl_pkg::DIFF_W-1];
		if (raw_step > dtsl_pkg::RAW_STEP_W'(step_limit)) begin
			info.step = step_limit;
		end else begin
			info.step = raw_step[dtsl_pkg::LIMIT_W-1:0];
		end
	end
endmodule

// ===== rtl/dtsl_next.sv =====
// Next displayed temperature: overshoot landing, minimum step, saturation.
module dtsl_next (
	input  logic signed [dtsl_pkg::TEMP_W-1:0]     measured_temp,
	input  logic signed [dtsl_pkg::TEMP_W-1:0]     shown_temp,
	input  logic                                   slew_en,
	input  dtsl_pkg::step_info_t                   info,
	input  logic [dtsl_pkg::MIN_STEP_W-1:0]        min_step,
	output logic signed [dtsl_pkg::TEMP_W-1:0]     next_temp,
	output logic                                   reached
);
	logic [dtsl_pkg::MOVE_W-1:0]          move;
	logic signed [dtsl_pkg::NEXT_W-1:0]   moved;

	always_comb begin
		move = dtsl_pkg::MOVE_W'(info.step);
		if (info.mag > dtsl_pkg::TEMP_W'(min_step)
				&& info.step < dtsl_pkg::LIMIT_W'(min_step)) begin
			move = dtsl_pkg::MOVE_W'(info.step) + dtsl_pkg::MOVE_W'(min_step);
		end
	end

	always_comb begin
		if (info.neg) begin
			moved = dtsl_pkg::NEXT_W'(shown_temp) - signed'({6'd0, move});
		end else begin
			moved = dtsl_pkg::NEXT_W'(shown_temp) + signed'({6'd0, move});
		end
	end

	always_comb begin
		// jump straight to the measurement when control is off, the heater is idle or the step overshoots
		priority if (!slew_en || info.mag < dtsl_pkg::TEMP_W'(info.step)) begin
			next_temp = measured_temp;
		end else if (moved < dtsl_pkg::NEXT_W'(dtsl_pkg::TEMP_MIN)) begin
			next_temp = dtsl_pkg::TEMP_MIN;
		end else if (moved > dtsl_pkg::NEXT_W'(dtsl_pkg::TEMP_MAX)) begin
			next_temp = dtsl_pkg::TEMP_MAX;
		end else begin
			next_temp = moved[dtsl_pkg::TEMP_W-1:0];
		end
	end

	assign reached = (next_temp == measured_temp);
endmodule
